>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; every user has clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types, constants and calibration decode for the barometric
// temperature and pressure compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package btpc_pkg;

  // field widths
  localparam int RAW_W      = 24;
  localparam int OUT_W      = 32;
  localparam int D_W        = 25;   // raw temperature minus scaled t1
  localparam int TL_W       = 31;   // linearized temperature, full value
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 4;

  // structure
  localparam int QUEUE_DEPTH = 4;
  localparam int BACK_STAGES = 9;

  // fixed-point shifts
  localparam int T1_SHIFT      = 8;
  localparam int QUAD_SHIFT    = 12;
  localparam int TEMP_SHIFT    = 14;
  localparam int GAIN_SQ_SHIFT = 13;
  localparam int OFFS_SHIFT    = 17;
  localparam int SPAN_SHIFT    = 6;
  localparam int SQ_SHIFT      = 10;
  localparam int SECOND_SHIFT  = 5;
  localparam int CUBE_SHIFT    = 3;
  localparam int LINC_SHIFT    = 3;
  localparam int CUBE_P9_SHIFT = 15;
  localparam int SQ8_SHIFT     = 13;
  localparam int CST_SHIFT     = 13;
  localparam int OUT_SHIFT     = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CALIB    = 4'd0,
    REG_PRESS_CALIB_A = 4'd1,
    REG_PRESS_CALIB_B = 4'd2,
    REG_PRESS_CALIB_C = 4'd3
  } cfg_reg_e;

  // decoded coefficients, raw bit patterns
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [7:0]  p3;
    logic [7:0]  p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [7:0]  p7;
    logic [7:0]  p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } calib_t;

  // word handed from front to back
  typedef struct packed {
    logic [D_W-1:0]   d;
    logic [RAW_W-1:0] ap;
  } item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic calib_t decode_calib(input logic [39:0] tc,
                                          input logic [47:0] pa,
                                          input logic [47:0] pb,
                                          input logic [31:0] pc);
    calib_t c;
    c.t1  = tc[15:0];
    c.t2  = tc[31:16];
    c.t3  = tc[39:32];
    c.p1  = pa[15:0];
    c.p2  = pa[31:16];
    c.p3  = pa[39:32];
    c.p4  = pa[47:40];
    c.p5  = pb[15:0];
    c.p6  = pb[31:16];
    c.p7  = pb[39:32];
    c.p8  = pb[47:40];
    c.p9  = pc[15:0];
    c.p10 = pc[23:16];
    c.p11 = pc[31:24];
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/btpc_front.sv
// ----------------------------------------------------------------------------
// btpc_front
// Takes input words, forms the offset raw temperature and hands the word
// to the queue through a one-entry holding register.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [23:0]              raw_temperature_i,
  input  logic [23:0]              raw_pressure_i,
  input  logic [15:0]              t1_i,
  input  btpc_pkg::q_status_t      q_stat_i,
  output logic                     push_o,
  output btpc_pkg::item_t          item_o
);
  import btpc_pkg::*;

  logic  f_vld_d, f_vld_q;
  item_t f_item_q;
  logic  accept;

  // handshake with input side and queue
  always_comb begin
    in_stall_o = f_vld_q && q_stat_i.full;
    push_o     = f_vld_q && !q_stat_i.full;
    accept     = in_valid_i && !in_stall_o;
    f_vld_d    = accept || (f_vld_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= f_vld_d;
    end
  end

  // raw temperature minus t1 scaled, fits signed 25 bits
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_item_q.d  <= D_W'({1'b0, raw_temperature_i}) - (D_W'(t1_i) << T1_SHIFT);
      f_item_q.ap <= raw_pressure_i;
    end
  end

  assign item_o = f_item_q;

endmodule

`default_nettype wire

>>> hw/rtl/btpc_queue.sv
// ----------------------------------------------------------------------------
// btpc_queue
// Small first-in first-out buffer that decouples the front from the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_queue #(
  parameter int Depth = btpc_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  btpc_pkg::item_t     item_i,
  input  logic                pop_i,
  output btpc_pkg::item_t     item_o,
  output btpc_pkg::q_status_t stat_o
);
  import btpc_pkg::*;

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;

  // pointers wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

>>> hw/rtl/btpc_back.sv
// ----------------------------------------------------------------------------
// btpc_back
// Nine-stage arithmetic pipeline: temperature polynomial, pressure gain,
// square and cube terms, final sum. At most one multiplier level per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btpc_pkg::calib_t    cal_i,
  input  btpc_pkg::item_t     item_i,
  input  btpc_pkg::q_status_t q_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  temperature_o,
  output logic signed [31:0]  pressure_o
);
  import btpc_pkg::*;

  logic [BACK_STAGES-1:0] vld_d, vld_q;
  logic                   en;

  // stage 1
  logic signed [41:0] lin_a_d, lin_a1_q, lin_a2_q;
  logic signed [49:0] dsq_full;
  logic [46:0]        dsq1_q;
  logic [47:0]        app_d, app1_q;
  logic signed [32:0] lb_d, lb1_q, lb2_q, lc_d, lc1_q, lc2_q;
  logic [RAW_W-1:0]   ap1_q, ap2_q, ap3_q, ap4_q, ap5_q, ap6_q;
  // stage 2
  logic signed [55:0] quad_d, quad2_q;
  logic [62:0]        sqp_d, sqp2_q;
  logic [55:0]        cl_d, cl2_q;
  logic [39:0]        ch_d, ch2_q;
  logic signed [56:0] sq8p_d, sq8p2_q;
  // stage 3
  logic signed [63:0]     tsum;
  logic signed [TL_W-1:0] tl_d, tl3_q, tl4_q, tl5_q, tl6_q, tl7_q, tl8_q;
  logic [63:0]            cube_raw;
  logic signed [63:0]     cube_d, cube3_q;
  logic signed [63:0]     sec_sum, sec_d, sec3_q;
  logic signed [63:0]     sq8_d, sq8_3_q, lcs_d, lcs3_q;
  // stage 4
  logic signed [61:0] tt_d, tt4_q;
  logic signed [46:0] h_d, h4_q, h5_q;
  logic signed [48:0] cpl_d, cpl4_q;
  logic [31:0]        cph_d, cph4_q;
  logic signed [63:0] rest4_d, rest4_q;
  // stage 5
  logic signed [68:0] gp_d;
  logic [63:0]        g5_q;
  logic [63:0]        cp_raw;
  logic signed [63:0] cubep_d, cubep5_q, rest5_d, rest5_q;
  // stage 6
  logic signed [63:0] gain_d, gain6_q, rest6_q;
  // stage 7
  logic [55:0]        sl_d, sl7_q, sh_d;
  logic [31:0]        sh7_q;
  logic signed [63:0] rest7_q;
  // stage 8
  logic [63:0]        span_raw;
  logic signed [63:0] span_d, span8_q, rest8_q;
  // stage 9
  logic signed [63:0] pl_d;
  logic signed [31:0] temp9_q, pres9_q;

  // pipeline moves as a whole unless the output word is held
  always_comb begin
    en    = !(vld_q[BACK_STAGES-1] && out_stall_i);
    pop_o = en && !q_stat_i.empty;
    vld_d = en ? {vld_q[BACK_STAGES-2:0], pop_o} : vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: products of raw inputs
  always_comb begin
    lin_a_d  = $signed(item_i.d) * $signed({1'b0, cal_i.t2});
    dsq_full = $signed(item_i.d) * $signed(item_i.d);
    app_d    = item_i.ap * item_i.ap;
    lb_d     = $signed(cal_i.p4) * $signed({1'b0, item_i.ap});
    lc_d     = $signed(cal_i.p10) * $signed({1'b0, item_i.ap});
  end

  // stage 2: quadratic temperature term, pressure square and cube parts
  always_comb begin
    quad_d = $signed({1'b0, dsq1_q}) * $signed(cal_i.t3);
    sqp_d  = app1_q[47:1] * cal_i.p6;
    cl_d   = ap1_q * app1_q[31:0];
    ch_d   = ap1_q * app1_q[47:32];
    sq8p_d = $signed(cal_i.p8) * $signed({1'b0, app1_q});
  end

  // stage 3: linearized temperature, wrapped cube, second-order sum
  always_comb begin
    tsum     = 64'(lin_a2_q) + (64'(quad2_q) >>> QUAD_SHIFT);
    tl_d     = TL_W'(tsum >>> TEMP_SHIFT);
    cube_raw = 64'(cl2_q) + {ch2_q[31:0], 32'h0};
    cube_d   = $signed(cube_raw) >>> CUBE_SHIFT;
    sec_sum  = $signed(64'(sqp2_q >> SQ_SHIFT)) + (64'(lb2_q) >>> 1)
             + (64'($signed(cal_i.p7)) <<< CST_SHIFT);
    sec_d    = sec_sum >>> SECOND_SHIFT;
    sq8_d    = 64'(sq8p2_q) >>> SQ8_SHIFT;
    lcs_d    = 64'(lc2_q) >>> LINC_SHIFT;
  end

  // stage 4: temperature square, p2 term, cube times p9 halves
  // upper half only needs the low 32 product bits, p9 sign-extended
  always_comb begin
    tt_d    = tl3_q * tl3_q;
    h_d     = $signed(cal_i.p2) * tl3_q;
    cpl_d   = $signed({1'b0, cube3_q[31:0]}) * $signed(cal_i.p9);
    cph_d   = cube3_q[63:32] * {{16{cal_i.p9[15]}}, cal_i.p9};
    rest4_d = sec3_q + sq8_3_q + lcs3_q;
  end

  // stage 5: p3 term wraps to 64 bits, cube term finished
  always_comb begin
    gp_d    = (tt4_q >>> 1) * $signed(cal_i.p3);
    cp_raw  = 64'(cpl4_q) + {cph4_q, 32'h0};
    cubep_d = $signed(cp_raw) >>> CUBE_P9_SHIFT;
    rest5_d = rest4_q + $signed(64'(cal_i.p5) << OFFS_SHIFT)
            + (64'($signed(cal_i.p11)) <<< CST_SHIFT);
  end

  // stage 6: pressure gain
  always_comb begin
    gain_d = ($signed(g5_q) >>> GAIN_SQ_SHIFT) + (64'(h5_q) >>> 1)
           + (64'($signed(cal_i.p1)) <<< OFFS_SHIFT);
  end

  // stage 7: raw pressure times gain, split in 32-bit halves
  always_comb begin
    sl_d = ap6_q * gain6_q[31:0];
    sh_d = ap6_q * gain6_q[63:32];
  end

  // stages 8 and 9: span and final sum
  always_comb begin
    span_raw = 64'(sl7_q) + {sh7_q, 32'h0};
    span_d   = $signed(span_raw) >>> SPAN_SHIFT;
    pl_d     = span8_q + rest8_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lin_a1_q <= lin_a_d;
      dsq1_q   <= dsq_full[47:1];
      app1_q   <= app_d;
      lb1_q    <= lb_d;
      lc1_q    <= lc_d;
      ap1_q    <= item_i.ap;

      quad2_q  <= quad_d;
      lin_a2_q <= lin_a1_q;
      sqp2_q   <= sqp_d;
      cl2_q    <= cl_d;
      ch2_q    <= ch_d;
      sq8p2_q  <= sq8p_d;
      lb2_q    <= lb1_q;
      lc2_q    <= lc1_q;
      ap2_q    <= ap1_q;

      tl3_q    <= tl_d;
      cube3_q  <= cube_d;
      sec3_q   <= sec_d;
      sq8_3_q  <= sq8_d;
      lcs3_q   <= lcs_d;
      ap3_q    <= ap2_q;

      tt4_q    <= tt_d;
      h4_q     <= h_d;
      cpl4_q   <= cpl_d;
      cph4_q   <= cph_d;
      rest4_q  <= rest4_d;
      tl4_q    <= tl3_q;
      ap4_q    <= ap3_q;

      g5_q     <= gp_d[63:0];
      cubep5_q <= cubep_d;
      h5_q     <= h4_q;
      rest5_q  <= rest5_d;
      tl5_q    <= tl4_q;
      ap5_q    <= ap4_q;

      gain6_q  <= gain_d;
      rest6_q  <= rest5_q + cubep5_q;
      tl6_q    <= tl5_q;
      ap6_q    <= ap5_q;

      sl7_q    <= sl_d;
      sh7_q    <= sh_d[31:0];
      rest7_q  <= rest6_q;
      tl7_q    <= tl6_q;

      span8_q  <= span_d;
      rest8_q  <= rest7_q;
      tl8_q    <= tl7_q;

      temp9_q  <= OUT_W'(tl8_q);
      pres9_q  <= pl_d[OUT_SHIFT + OUT_W - 1:OUT_SHIFT];
    end
  end

  assign out_valid_o   = vld_q[BACK_STAGES-1];
  assign temperature_o = temp9_q;
  assign pressure_o    = pres9_q;

endmodule

`default_nettype wire

>>> hw/rtl/baro_temp_press_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_top
// Integer temperature and pressure compensation from raw 24-bit samples
// with fourteen calibration coefficients held in four registers.
//
//   port group   dir  handshake              payload
//   input word   in   in_valid_i/in_stall_o  raw_temperature_i, raw_pressure_i
//   result word  out  out_valid_o/out_stall_i temperature_o, pressure_o
//   config       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// One word per cycle while no result word is held, set by the nine-stage
// multiply pipeline. Words pass the front register, queue, then the stages.
// Reset clears the calibration registers to zero; there is no clearing pass.
// A held result freezes the pipeline; the four-entry queue then fills and
// in_stall_o rises once the front holding register cannot drain.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module baro_temp_press_compensation_top #(
  parameter int QueueDepth = btpc_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [23:0]                        raw_temperature_i,
  input  logic [23:0]                        raw_pressure_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [31:0]                 temperature_o,
  output logic signed [31:0]                 pressure_o,
  input  logic                               cfg_we_i,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [btpc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import btpc_pkg::*;

  logic [39:0] temp_calib_q;
  logic [47:0] press_calib_a_q;
  logic [47:0] press_calib_b_q;
  logic [31:0] press_calib_c_q;
  calib_t      cal;

  logic        q_push, q_pop;
  item_t       f_item, q_item;
  q_status_t   q_stat;

  // calibration registers, writes beyond the last index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q    <= '0;
      press_calib_a_q <= '0;
      press_calib_b_q <= '0;
      press_calib_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEMP_CALIB:    temp_calib_q    <= cfg_data_i[39:0];
        REG_PRESS_CALIB_A: press_calib_a_q <= cfg_data_i[47:0];
        REG_PRESS_CALIB_B: press_calib_b_q <= cfg_data_i[47:0];
        REG_PRESS_CALIB_C: press_calib_c_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cal = decode_calib(temp_calib_q, press_calib_a_q, press_calib_b_q,
                            press_calib_c_q);

  btpc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .t1_i              (cal.t1),
    .q_stat_i          (q_stat),
    .push_o            (q_push),
    .item_o            (f_item)
  );

  btpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (f_item),
    .pop_i  (q_pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  btpc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cal_i         (cal),
    .item_i        (q_item),
    .q_stat_i      (q_stat),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .temperature_o (temperature_o),
    .pressure_o    (pressure_o)
  );

  // checks
  `ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result word during reset")
  `ASSERT_ON(a_queue_flags, !(q_stat.full && q_stat.empty), "queue full and empty together")
  `ASSERT_ON(a_held_no_pop, out_valid_o && out_stall_i |-> !q_pop, "queue popped while held")
  `ASSERT_ON(a_push_lands, q_push && q_stat.empty |=> !q_stat.empty, "pushed word lost")

endmodule

`default_nettype wire

>>> tb/btpc_result_checker.sv
// ----------------------------------------------------------------------------
// btpc_result_checker
// Watches the input, result and calibration ports of the compensation block,
// keeps its own copy of the four calibration registers, predicts the
// temperature and pressure of every accepted input word in 64-bit wrapping
// arithmetic and compares each accepted result word, in order, field by field.
// ----------------------------------------------------------------------------
module btpc_result_checker
  import btpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [RAW_W-1:0]      raw_temperature_i,
  input  logic [RAW_W-1:0]      raw_pressure_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic signed [31:0]    temperature_i,
  input  logic signed [31:0]    pressure_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] pressure;
  } comp_result_t;

  localparam int unsigned MaxPrinted = 40;

  logic [39:0] temp_calib_q;
  logic [47:0] press_a_q;
  logic [47:0] press_b_q;
  logic [31:0] press_c_q;

  comp_result_t expected_results[$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;

  assign fail_count_o = mismatches;

  initial pending_o = 0;

  // one printed line per mismatch, printing capped, counting not
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MaxPrinted) begin
      $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // expected result word for one sample pair under the current calibration
  function automatic comp_result_t compensate(input logic [RAW_W-1:0] raw_t,
                                              input logic [RAW_W-1:0] raw_p);
    logic signed [63:0] at, ap;
    logic signed [63:0] t1, t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic signed [63:0] d, lin_a, quad, tl;
    logic signed [63:0] g, h, k, gain, span, offs;
    logic signed [63:0] sq, lin_b, cst, second, cube, sq8, lin_c, acc;
    comp_result_t r;
    at  = {40'd0, raw_t};
    ap  = {40'd0, raw_p};
    // unsigned fields zero-extend, the rest sign-extend
    t1  = {48'd0, temp_calib_q[15:0]};
    t2  = {48'd0, temp_calib_q[31:16]};
    t3  = {{56{temp_calib_q[39]}}, temp_calib_q[39:32]};
    p1  = {{48{press_a_q[15]}}, press_a_q[15:0]};
    p2  = {{48{press_a_q[31]}}, press_a_q[31:16]};
    p3  = {{56{press_a_q[39]}}, press_a_q[39:32]};
    p4  = {{56{press_a_q[47]}}, press_a_q[47:40]};
    p5  = {48'd0, press_b_q[15:0]};
    p6  = {48'd0, press_b_q[31:16]};
    p7  = {{56{press_b_q[39]}}, press_b_q[39:32]};
    p8  = {{56{press_b_q[47]}}, press_b_q[47:40]};
    p9  = {{48{press_c_q[15]}}, press_c_q[15:0]};
    p10 = {{56{press_c_q[23]}}, press_c_q[23:16]};
    p11 = {{56{press_c_q[31]}}, press_c_q[31:24]};

    // linearized temperature
    d     = at - (t1 <<< T1_SHIFT);
    lin_a = d * t2;
    quad  = d * d;
    quad  = quad >>> 1;
    quad  = quad * t3;
    quad  = quad >>> QUAD_SHIFT;
    tl    = lin_a + quad;
    tl    = tl >>> TEMP_SHIFT;

    // gain set by temperature
    g     = tl * tl;
    g     = g >>> 1;
    g     = g * p3;
    g     = g >>> GAIN_SQ_SHIFT;
    h     = p2 * tl;
    h     = h >>> 1;
    k     = p1 <<< OFFS_SHIFT;
    gain  = g + h + k;
    span  = ap * gain;
    span  = span >>> SPAN_SHIFT;
    offs  = p5 <<< OFFS_SHIFT;

    // square terms
    sq     = ap * ap;
    sq     = sq >>> 1;
    sq     = sq * p6;
    sq     = sq >>> SQ_SHIFT;
    lin_b  = p4 * ap;
    lin_b  = lin_b >>> 1;
    cst    = p7 <<< CST_SHIFT;
    second = sq + lin_b + cst;
    second = second >>> SECOND_SHIFT;

    // cube terms, the cube itself wraps
    cube  = ap * ap * ap;
    cube  = cube >>> CUBE_SHIFT;
    cube  = cube * p9;
    cube  = cube >>> CUBE_P9_SHIFT;
    sq8   = p8 * ap * ap;
    sq8   = sq8 >>> SQ8_SHIFT;
    lin_c = p10 * ap;
    lin_c = lin_c >>> LINC_SHIFT;

    acc = span + offs + second + cube + sq8 + lin_c + (p11 <<< CST_SHIFT);
    acc = acc >>> OUT_SHIFT;
    r.temperature = tl[31:0];
    r.pressure    = acc[31:0];
    return r;
  endfunction

  // calibration shadow, masked to register widths, other indexes ignored
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_a_q    <= '0;
      press_b_q    <= '0;
      press_c_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP_CALIB:    temp_calib_q <= cfg_data_i[39:0];
        REG_PRESS_CALIB_A: press_a_q    <= cfg_data_i[47:0];
        REG_PRESS_CALIB_B: press_b_q    <= cfg_data_i[47:0];
        REG_PRESS_CALIB_C: press_c_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // result words are checked before this edge's input word is queued
  always @(posedge clk_i) begin
    comp_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word, temperature/pressure",
                          temperature_i, pressure_i);
        end else begin
          want = expected_results.pop_front();
          if (temperature_i !== want.temperature) begin
            report_mismatch("temperature", temperature_i, want.temperature);
          end
          if (pressure_i !== want.pressure) begin
            report_mismatch("pressure", pressure_i, want.pressure);
          end
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(compensate(raw_temperature_i, raw_pressure_i));
      end
    end
    pending_o <= expected_results.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the compensation block: corner samples under zero, all-ones,
// most-negative and most-positive calibration, then random sample pairs under
// a series of random calibration settings, with random gaps on both sides,
// one long result hold-off and a stretch without gaps. Prediction and
// comparison live in the result checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btpc_pkg::*;

  localparam int unsigned IdlePct     = 37;
  localparam int unsigned RandPhases  = 6;
  localparam int unsigned PhaseWords  = 300;
  localparam int unsigned HoldAt      = 700;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned CalmFrom    = 1100;
  localparam int unsigned CalmTo      = 1300;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned TailCycles  = 20;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [RAW_W-1:0]      raw_temperature_i;
  logic [RAW_W-1:0]      raw_pressure_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [31:0]    temperature_o;
  logic signed [31:0]    pressure_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned in_words = 0;
  int unsigned out_words = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_settings = 0;
  logic [39:0] cur_tc = '0;
  logic        hold_done = 1'b0;
  logic        calm;

  baro_temp_press_compensation_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .temperature_o     (temperature_o),
    .pressure_o        (pressure_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  btpc_result_checker u_result_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .temperature_i     (temperature_o),
    .pressure_i        (pressure_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // word counters, read by the drivers at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) in_words <= in_words + 1;
    if (rst_ni && out_valid_o && !out_stall_i) out_words <= out_words + 1;
  end

  // no gaps on either side in this window
  assign calm = (in_words >= CalmFrom) && (in_words < CalmTo);

  // watchdog on cycles with no word and no register write
  initial begin
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: %0d cycles without progress, %0d results pending",
             QuietLimit, pending);
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall, one long hold-off once the stream is deep
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && in_words >= HoldAt) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [RAW_W-1:0] edge_sample();
    case ($urandom_range(3))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h800000;
      default: return 24'h7FFFFF;
    endcase
  endfunction

  // offer one word from a falling edge, return at the falling edge after it
  task automatic send_word(input logic [RAW_W-1:0] t, input logic [RAW_W-1:0] p);
    while (!calm && ($urandom_range(99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_temperature_i <= t;
    raw_pressure_i    <= p;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every pending result word
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // all four registers, then one write to an unused index that must be ignored
  task automatic load_calib(input logic [47:0] tc, input logic [47:0] pa,
                            input logic [47:0] pb, input logic [47:0] pc);
    put_reg(REG_TEMP_CALIB, tc);
    put_reg(REG_PRESS_CALIB_A, pa);
    put_reg(REG_PRESS_CALIB_B, pb);
    put_reg(REG_PRESS_CALIB_C, pc);
    put_reg(CFG_IDX_W'(REG_PRESS_CALIB_C) + 4'd1 + CFG_IDX_W'($urandom_range(11)), rand48());
    cfg_we_i <= 1'b0;
    cur_tc = tc[39:0];
    n_settings++;
  endtask

  // raw extremes, plus a temperature that cancels the t1 offset exactly
  task automatic send_corners();
    send_word(24'h000000, 24'h000000);
    send_word(24'hFFFFFF, 24'hFFFFFF);
    send_word(24'h000000, 24'hFFFFFF);
    send_word(24'hFFFFFF, 24'h000000);
    send_word(24'h800000, 24'h7FFFFF);
    send_word({cur_tc[15:0], 8'h00}, 24'h800000);
  endtask

  // main sequence
  initial begin
    logic [RAW_W-1:0] t, p;
    int unsigned      kind;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    raw_temperature_i = '0;
    raw_pressure_i    = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_TEMP_CALIB;
    cfg_data_i        = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero calibration straight after reset
    n_settings = 1;
    send_corners();

    // all ones, excess register bits set as well
    drain_results();
    load_calib(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
               48'hFFFF_FFFF_FFFF);
    send_corners();

    // signed fields most negative, unsigned fields at maximum
    drain_results();
    load_calib({8'h00, 8'h80, 16'hFFFF, 16'hFFFF}, {8'h80, 8'h80, 16'h8000, 16'h8000},
               {8'h80, 8'h80, 16'hFFFF, 16'hFFFF}, {16'h0000, 8'h80, 8'h80, 16'h8000});
    send_corners();

    // signed fields most positive, mixed unsigned fields
    drain_results();
    load_calib({8'h00, 8'h7F, 16'hFFFF, 16'h0000}, {8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF},
               {8'h7F, 8'h7F, 16'h0000, 16'hFFFF}, {16'h0000, 8'h7F, 8'h7F, 16'h7FFF});
    send_corners();

    // random calibration settings, each with a batch of random words
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain_results();
      load_calib(rand48(), rand48(), rand48(), rand48());
      for (int n = 0; n < PhaseWords; n++) begin
        kind = $urandom_range(99);
        if (kind < 10) begin
          t = edge_sample();
          p = edge_sample();
        end else if (kind < 25) begin
          t = RAW_W'({cur_tc[15:0], 8'h00}) + RAW_W'($urandom_range(1023)) - 24'd512;
          p = RAW_W'($urandom());
        end else begin
          t = RAW_W'($urandom());
          p = RAW_W'($urandom());
        end
        send_word(t, p);
      end
    end

    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    $display("covered %0d input words and %0d result words over %0d calibration settings",
             in_words, out_words, n_settings);
    $display("included a %0d-cycle result hold-off and a gap-free stretch", HoldCycles);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
